// ===== rtl/quaternion_to_euler_angles_unit_assert.svh =====
// Assertion macros used by the checker file of the quaternion converter.
`ifndef QUATERNION_TO_EULER_ANGLES_UNIT_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_UNIT_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define Q2E_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define Q2E_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/q2e_pkg.sv =====
// ----------------------------------------------------------------------------
// q2e_pkg
// Widths, types and constant tables of the quaternion to Euler converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int ANGLE_ITERATIONS = 16;
  localparam int ATAN_TABLE_LEN   = 24;
  localparam int CORDIC_STAGES    =
    (ANGLE_ITERATIONS < ATAN_TABLE_LEN) ? ANGLE_ITERATIONS : ATAN_TABLE_LEN;
  localparam int SQRT_STEPS  = 32;
  localparam int FRONT_LAT   = 3;
  localparam int LANES       = 3;
  localparam int SW          = 34;   // sums of products, units of 2^-30
  localparam int CW          = 37;   // CORDIC x/y datapath
  localparam int AW          = 32;   // angle accumulator
  localparam int QW          = 63;   // square-root datapath
  localparam int LAT         = FRONT_LAT + SQRT_STEPS + 1 + CORDIC_STAGES + 1;

  localparam logic signed [AW-1:0] HALF_TURN_ACC = 32'sd1179648000;

  typedef logic signed [SW-1:0] sum_t;
  typedef logic signed [CW-1:0] cw_t;
  typedef logic signed [AW-1:0] acc_t;
  typedef logic [QW-1:0]        sq_t;

  typedef struct packed {
    sum_t        yz;       // numerator of angle Z
    sum_t        xz;       // denominator of angle Z
    sum_t        yx;       // numerator of angle X
    sum_t        xx;       // denominator of angle X
    logic signed [31:0] s; // saturated arcsine argument, +-2^30 inclusive
    logic        clamped;
  } carry_t;

  typedef struct packed {
    carry_t      c;
    logic [60:0] sq;       // s squared
  } front_t;

  function automatic acc_t atan_step(input logic [4:0] idx);
    acc_t t;
    case (idx)
      5'd0:  t = 32'sd294912000;
      5'd1:  t = 32'sd174096719;
      5'd2:  t = 32'sd91987925;
      5'd3:  t = 32'sd46694507;
      5'd4:  t = 32'sd23437865;
      5'd5:  t = 32'sd11730358;
      5'd6:  t = 32'sd5866610;
      5'd7:  t = 32'sd2933484;
      5'd8:  t = 32'sd1466764;
      5'd9:  t = 32'sd733385;
      5'd10: t = 32'sd366693;
      5'd11: t = 32'sd183346;
      5'd12: t = 32'sd91673;
      5'd13: t = 32'sd45837;
      5'd14: t = 32'sd22918;
      5'd15: t = 32'sd11459;
      5'd16: t = 32'sd5730;
      5'd17: t = 32'sd2865;
      5'd18: t = 32'sd1432;
      5'd19: t = 32'sd716;
      5'd20: t = 32'sd358;
      5'd21: t = 32'sd179;
      5'd22: t = 32'sd90;
      5'd23: t = 32'sd45;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Accumulator to hundredths (half away from zero), then saturate to lim.
  function automatic logic signed [16:0] acc_round_sat(input acc_t a,
                                                       input logic [14:0] lim);
    logic signed [32:0] ax;
    logic signed [32:0] mag;
    logic signed [16:0] r;
    ax  = 33'(a);
    mag = (ax < 0) ? -ax : ax;
    mag = (mag + 33'sd32768) >>> 16;
    r   = (ax < 0) ? -17'(mag) : 17'(mag);
    if (r > $signed({2'b00, lim})) begin
      r = $signed({2'b00, lim});
    end else if (r < -$signed({2'b00, lim})) begin
      r = -$signed({2'b00, lim});
    end
    return r;
  endfunction

endpackage

// ===== rtl/quaternion_to_euler_angles_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit
// Converts a Q1.15 quaternion to three Euler angles in hundredths of a degree.
// ----------------------------------------------------------------------------
// The unit takes one quaternion beat per clock cycle and returns one angle
// beat per quaternion, in order. The pipeline is made of three front-end
// stages (products, sums with the arcsine clamp, squaring), a chain of 32
// square-root cells, one quadrant stage, 16 CORDIC cells and one rounding
// stage. The whole pipeline advances together; it halts only while a
// finished result waits in the output register and the downstream side is
// not ready, so throughput is one beat per cycle whenever the consumer keeps
// up.
module quaternion_to_euler_angles_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] angle_x,
  output logic signed [14:0] angle_y,
  output logic signed [15:0] angle_z,
  output logic               clamped
);
  import q2e_pkg::*;

  // Global advance: every stage moves unless the output holds a beat
  // that has not been taken.
  logic           en;
  logic [LAT-1:0] vld;

  assign en        = !(vld[LAT-1] && !out_ready);
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Front end.
  front_t fr;

  q2e_front u_front (
    .clk    (clk),
    .en     (en),
    .quat_w (quat_w),
    .quat_x (quat_x),
    .quat_y (quat_y),
    .quat_z (quat_z),
    .res    (fr)
  );

  // Square-root chain computes c = floor(sqrt(2^60 - s^2)); the other
  // operands ride alongside it in a matching delay line.
  sq_t    sv [0:SQRT_STEPS];
  sq_t    sr [0:SQRT_STEPS];
  carry_t cr [0:SQRT_STEPS];

  assign sv[0] = {2'b00, 61'h1000000000000000 - fr.sq};
  assign sr[0] = '0;
  assign cr[0] = fr.c;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    q2e_sqrt_cell u_cell (
      .clk   (clk),
      .en    (en),
      .step  (5'(k)),
      .v_in  (sv[k]),
      .r_in  (sr[k]),
      .v_out (sv[k+1]),
      .r_out (sr[k+1])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        cr[k+1] <= cr[k];
      end
    end
  end

  // Quadrant stage. Lane 0 gives angle Z, lane 1 angle X, lane 2 angle Y.
  // A negative x is folded onto the right half plane with a half-turn base.
  cw_t  ly [0:LANES-1];
  cw_t  lx [0:LANES-1];
  cw_t  cx [0:LANES-1][0:CORDIC_STAGES];
  cw_t  cy [0:LANES-1][0:CORDIC_STAGES];
  acc_t ca [0:LANES-1][0:CORDIC_STAGES];
  logic clmp [0:CORDIC_STAGES];

  assign ly[0] = CW'(cr[SQRT_STEPS].yz);
  assign lx[0] = CW'(cr[SQRT_STEPS].xz);
  assign ly[1] = CW'(cr[SQRT_STEPS].yx);
  assign lx[1] = CW'(cr[SQRT_STEPS].xx);
  assign ly[2] = CW'(cr[SQRT_STEPS].s);
  assign lx[2] = CW'({1'b0, sr[SQRT_STEPS][30:0]});

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    always_ff @(posedge clk) begin
      if (en) begin
        if (lx[l] < 0) begin
          cx[l][0] <= -lx[l];
          cy[l][0] <= -ly[l];
          ca[l][0] <= (ly[l] >= 0) ? HALF_TURN_ACC : -HALF_TURN_ACC;
        end else begin
          cx[l][0] <= lx[l];
          cy[l][0] <= ly[l];
          ca[l][0] <= '0;
        end
      end
    end

    for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_stage
      q2e_cordic_cell u_cell (
        .clk   (clk),
        .en    (en),
        .step  (5'(j)),
        .x_in  (cx[l][j]),
        .y_in  (cy[l][j]),
        .a_in  (ca[l][j]),
        .x_out (cx[l][j+1]),
        .y_out (cy[l][j+1]),
        .a_out (ca[l][j+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clmp[0] <= cr[SQRT_STEPS].clamped;
    end
  end

  for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_clmp
    always_ff @(posedge clk) begin
      if (en) begin
        clmp[j+1] <= clmp[j];
      end
    end
  end

  // Rounding to hundredths and range guard into the output register.
  logic signed [16:0] rz, rx, ry;

  assign rz = acc_round_sat(ca[0][CORDIC_STAGES], 15'd18000);
  assign rx = acc_round_sat(ca[1][CORDIC_STAGES], 15'd18000);
  assign ry = acc_round_sat(ca[2][CORDIC_STAGES], 15'd9000);

  always_ff @(posedge clk) begin
    if (en) begin
      angle_z <= rz[15:0];
      angle_x <= rx[15:0];
      angle_y <= ry[14:0];
      clamped <= clmp[CORDIC_STAGES];
    end
  end

endmodule

// ===== rtl/q2e_front.sv =====
// ----------------------------------------------------------------------------
// q2e_front
// Products, sums of products, arcsine clamp and the square of its argument.
// ----------------------------------------------------------------------------
module q2e_front (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  output q2e_pkg::front_t    res
);
  import q2e_pkg::*;

  logic signed [31:0] p_ww, p_xx, p_yy, p_zz, p_xy, p_zw, p_yz, p_xw, p_yw, p_xz;
  carry_t             sums;
  sum_t               s_wide;
  logic [30:0]        s_abs;

  always_ff @(posedge clk) begin
    if (en) begin
      p_ww <= quat_w * quat_w;
      p_xx <= quat_x * quat_x;
      p_yy <= quat_y * quat_y;
      p_zz <= quat_z * quat_z;
      p_xy <= quat_x * quat_y;
      p_zw <= quat_z * quat_w;
      p_yz <= quat_y * quat_z;
      p_xw <= quat_x * quat_w;
      p_yw <= quat_y * quat_w;
      p_xz <= quat_x * quat_z;
    end
  end

  assign s_wide = (SW'(p_yw) - SW'(p_xz)) <<< 1;

  always_ff @(posedge clk) begin
    if (en) begin
      sums.yz <= (SW'(p_xy) + SW'(p_zw)) <<< 1;
      sums.xz <= SW'(p_xx) - SW'(p_yy) - SW'(p_zz) + SW'(p_ww);
      sums.yx <= (SW'(p_yz) + SW'(p_xw)) <<< 1;
      sums.xx <= SW'(p_zz) + SW'(p_ww) - SW'(p_xx) - SW'(p_yy);
      if (s_wide > SW'(64'sd1073741824)) begin
        sums.s       <= 32'sd1073741824;
        sums.clamped <= 1'b1;
      end else if (s_wide < -SW'(64'sd1073741824)) begin
        sums.s       <= -32'sd1073741824;
        sums.clamped <= 1'b1;
      end else begin
        sums.s       <= 32'(s_wide);
        sums.clamped <= 1'b0;
      end
    end
  end

  assign s_abs = (sums.s < 0) ? 31'(-sums.s) : 31'(sums.s);

  always_ff @(posedge clk) begin
    if (en) begin
      res.c  <= sums;
      res.sq <= 61'(62'(s_abs) * 62'(s_abs));
    end
  end

endmodule

// ===== rtl/q2e_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One digit step of the exact integer square root.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell (
  input  logic          clk,
  input  logic          en,
  input  logic [4:0]    step,
  input  q2e_pkg::sq_t  v_in,
  input  q2e_pkg::sq_t  r_in,
  output q2e_pkg::sq_t  v_out,
  output q2e_pkg::sq_t  r_out
);
  import q2e_pkg::*;

  sq_t bit_w;
  sq_t trial;

  assign bit_w = QW'(1) << (6'd62 - {step, 1'b0});
  assign trial = r_in + bit_w;

  always_ff @(posedge clk) begin
    if (en) begin
      if (v_in >= trial) begin
        v_out <= v_in - trial;
        r_out <= (r_in >> 1) + bit_w;
      end else begin
        v_out <= v_in;
        r_out <= r_in >> 1;
      end
    end
  end

endmodule

// ===== rtl/q2e_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring CORDIC rotation toward the positive x axis.
// ----------------------------------------------------------------------------
module q2e_cordic_cell (
  input  logic          clk,
  input  logic          en,
  input  logic [4:0]    step,
  input  q2e_pkg::cw_t  x_in,
  input  q2e_pkg::cw_t  y_in,
  input  q2e_pkg::acc_t a_in,
  output q2e_pkg::cw_t  x_out,
  output q2e_pkg::cw_t  y_out,
  output q2e_pkg::acc_t a_out
);
  import q2e_pkg::*;

  cw_t  dx, dy;
  acc_t t;

  assign dx = y_in >>> step;
  assign dy = x_in >>> step;
  assign t  = atan_step(step);

  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in > 0) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        a_out <= a_in + t;
      end else if (y_in < 0) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        a_out <= a_in - t;
      end else begin
        x_out <= x_in;
        y_out <= y_in;
        a_out <= a_in;
      end
    end
  end

endmodule

// ===== rtl/q2e_checker.sv =====
// ----------------------------------------------------------------------------
// q2e_checker
// Port-level checks of the quaternion converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_angles_unit_assert.svh"

module q2e_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] angle_x,
  input logic signed [14:0] angle_y,
  input logic signed [15:0] angle_z,
  input logic               clamped
);

  // A stalled result beat holds.
  `Q2E_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({angle_x, angle_y, angle_z, clamped}))
  // The input side only stalls when a result beat is blocked.
  `Q2E_ASSERT_NOW(a_ready_stall, !in_ready, out_valid && !out_ready)
  // Angles stay inside their ranges.
  `Q2E_ASSERT_NOW(a_xz_range, out_valid, angle_x <= 16'sd18000 && angle_x >= -16'sd18000 && angle_z <= 16'sd18000 && angle_z >= -16'sd18000)
  `Q2E_ASSERT_NOW(a_y_range, out_valid, angle_y <= 15'sd9000 && angle_y >= -15'sd9000)

endmodule

bind quaternion_to_euler_angles_unit q2e_checker u_q2e_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .angle_x   (angle_x),
  .angle_y   (angle_y),
  .angle_z   (angle_z),
  .clamped   (clamped)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for quaternion_to_euler_angles_unit
// Drives quaternion beats through a valid/ready channel and checks every angle
// beat against a CORDIC-based angle predictor, under several idling phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [14:0] ay;
    logic signed [15:0] az;
    logic               clamp;
  } euler_t;

  localparam int ROTATION_STEPS = 16;
  localparam int PIPE_DEPTH     = 53;
  localparam int CYCLE_LIMIT    = 400000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] angle_x;
  logic signed [14:0] angle_y;
  logic signed [15:0] angle_z;
  logic clamped;

  quaternion_to_euler_angles_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z), .clamped(clamped)
  );

  // Stimulus queue filled by the initial block, expected angles queued by the
  // driver's acceptance monitor.
  quat_t  pending_quats[$];
  euler_t expected_angles[$];
  int     send_idle_pct;
  int     recv_stall_pct;
  bit     hold_sender;
  bit     in_accepted;
  int     error_count;
  int     cycle_count;

  // Table of atan(2^-i) in 1/65536 hundredths of a degree.
  function automatic longint atan_entry(input int i);
    longint t[24] = '{294912000, 174096719, 91987925, 46694507, 23437865,
                      11730358, 5866610, 2933484, 1466764, 733385, 366693,
                      183346, 91673, 45837, 22918, 11459, 5730, 2865, 1432,
                      716, 358, 179, 90, 45};
    return t[i];
  endfunction

  // Vectoring CORDIC angle of (x, y), rounded to hundredths of a degree.
  function automatic longint vector_angle(input longint y, input longint x);
    longint acc;
    longint dx, dy;
    acc = 0;
    if (x < 0) begin
      acc = (y >= 0) ? 64'sd1179648000 : -64'sd1179648000;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ROTATION_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        acc += atan_entry(i);
      end else if (y < 0) begin
        x -= dx;
        y += dy;
        acc -= atan_entry(i);
      end
    end
    if (acc >= 0) return (acc + 32768) >>> 16;
    return -((-acc + 32768) >>> 16);
  endfunction

  function automatic longint clip(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Floor square root, bit by bit.
  function automatic longint floor_sqrt(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic euler_t euler_of(input quat_t q);
    longint w, x, y, z, s, c, unit_one;
    euler_t e;
    w = q.w; x = q.x; y = q.y; z = q.z;
    unit_one = 64'sd1 << 30;
    e.clamp = 1'b0;
    e.az = 16'(clip(vector_angle(2 * (x * y + z * w), x*x - y*y - z*z + w*w), 18000));
    e.ax = 16'(clip(vector_angle(2 * (y * z + x * w), -x*x - y*y + z*z + w*w), 18000));
    s = 2 * (y * w - x * z);
    if (s > unit_one) begin
      s = unit_one;
      e.clamp = 1'b1;
    end else if (s < -unit_one) begin
      s = -unit_one;
      e.clamp = 1'b1;
    end
    c = floor_sqrt((64'd1 << 60) - longint'(s * s));
    e.ay = 15'(clip(vector_angle(s, c), 9000));
    return e;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Driver: presents the head of the queue on the falling edge; a beat stays
  // put until the monitor has seen it accepted at a rising edge.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_accepted) begin
      in_valid <= 1'b1;
    end else if (pending_quats.size() > 0 && !hold_sender &&
                 $urandom_range(99) >= send_idle_pct) begin
      in_valid <= 1'b1;
      quat_w   <= pending_quats[0].w;
      quat_x   <= pending_quats[0].x;
      quat_y   <= pending_quats[0].y;
      quat_z   <= pending_quats[0].z;
      void'(pending_quats.pop_front());
    end else begin
      in_valid <= 1'b0;
    end
    out_ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: an accepted quaternion queues its angles; an accepted angle beat
  // is checked against the oldest expectation.
  always @(posedge clk) begin
    euler_t want;
    in_accepted = in_valid && in_ready;
    if (!rst) begin
      cycle_count <= cycle_count + 1;
      if (in_valid && in_ready)
        expected_angles.insert(expected_angles.size(),
                               euler_of({quat_w, quat_x, quat_y, quat_z}));
      if (out_valid && out_ready) begin
        if (expected_angles.size() == 0) begin
          $display("%0t: angle beat with none expected", $realtime);
          error_count++;
        end else begin
          want = expected_angles.pop_front();
          if (angle_x !== want.ax) begin
            $display("%0t: angle_x expected %0d actual %0d", $realtime, want.ax, angle_x);
            error_count++;
          end
          if (angle_y !== want.ay) begin
            $display("%0t: angle_y expected %0d actual %0d", $realtime, want.ay, angle_y);
            error_count++;
          end
          if (angle_z !== want.az) begin
            $display("%0t: angle_z expected %0d actual %0d", $realtime, want.az, angle_z);
            error_count++;
          end
          if (clamped !== want.clamp) begin
            $display("%0t: clamped expected %0b actual %0b", $realtime, want.clamp, clamped);
            error_count++;
          end
        end
      end
    end
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("quaternion_to_euler_angles_unit verification failed");
      $finish;
    end
  end

  // A random quaternion: either raw random Q1.15 component bits, or four random
  // components scaled to roughly unit length.
  function automatic quat_t random_quat();
    quat_t q;
    int kind;
    real a, b, c, d, n;
    kind = $urandom_range(9);
    if (kind < 3) begin
      q = {$urandom, $urandom};
    end else begin
      a = $urandom_range(65535) - 32768.0;
      b = $urandom_range(65535) - 32768.0;
      c = $urandom_range(65535) - 32768.0;
      d = $urandom_range(65535) - 32768.0;
      n = $sqrt(a*a + b*b + c*c + d*d) + 1.0;
      q.w = 16'($rtoi(a / n * 32767.0));
      q.x = 16'($rtoi(b / n * 32767.0));
      q.y = 16'($rtoi(c / n * 32767.0));
      q.z = 16'($rtoi(d / n * 32767.0));
      // Sparse vectors hit the axis and zero cases.
      if (kind == 9) q.y = 0;
      if (kind == 8) q = {q.w, 16'sd0, 16'sd0, q.z};
    end
    return q;
  endfunction

  task automatic wait_drained();
    while (pending_quats.size() > 0 || in_valid || expected_angles.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    quat_t directed[$];
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    quat_w = '0; quat_x = '0; quat_y = '0; quat_z = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_sender = 1'b0;
    in_accepted = 1'b0;
    error_count = 0;
    cycle_count = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed beats: zero vector, identity, the unit axes, field extremes and
    // a near-unit arcsine argument.
    directed = '{
      quat_t'{16'sd0, 16'sd0, 16'sd0, 16'sd0},
      quat_t'{16'sd32767, 16'sd0, 16'sd0, 16'sd0},
      quat_t'{16'sd0, 16'sd32767, 16'sd0, 16'sd0},
      quat_t'{16'sd0, 16'sd0, 16'sd32767, 16'sd0},
      quat_t'{16'sd0, 16'sd0, 16'sd0, 16'sd32767},
      quat_t'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
      quat_t'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
      quat_t'{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767},
      quat_t'{16'sd23170, 16'sd0, 16'sd23170, 16'sd0},
      quat_t'{16'sd16384, 16'sd0, 16'sd16384, 16'sd0},
      quat_t'{16'sd16384, 16'sd16384, 16'sd0, 16'sd0},
      quat_t'{-16'sd16384, 16'sd0, 16'sd16384, 16'sd0},
      quat_t'{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384},
      quat_t'{16'sd23170, 16'sd23170, 16'sd0, 16'sd0},
      quat_t'{16'sd0, 16'sd23170, 16'sd0, 16'sd23170},
      quat_t'{16'sd1, -16'sd1, 16'sd1, -16'sd1},
      quat_t'{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA},
      quat_t'{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}
    };
    foreach (directed[i]) pending_quats.insert(pending_quats.size(), directed[i]);
    wait_drained();

    // Random phases with different idling, with a drained pause in the middle of phase 2.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      for (int n = 0; n < 170; n++) pending_quats.insert(pending_quats.size(), random_quat());
      if (phase == 2) begin
        while (pending_quats.size() > 0) @(posedge clk);
        hold_sender = 1'b1;
        wait_drained();
        hold_sender = 1'b0;
        for (int n = 0; n < 10; n++) pending_quats.insert(pending_quats.size(), random_quat());
      end
      wait_drained();
    end

    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("quaternion_to_euler_angles_unit verification clean");
    end else begin
      $display("quaternion_to_euler_angles_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== quaternion_to_euler_angles_unit.f =====
+incdir+rtl
rtl/q2e_pkg.sv
rtl/q2e_front.sv
rtl/q2e_sqrt_cell.sv
rtl/q2e_cordic_cell.sv
rtl/quaternion_to_euler_angles_unit.sv
rtl/q2e_checker.sv
tb/testbench.sv
